// ----- rtl/pgf_pkg.sv -----
`default_nettype none
package pgf_pkg;
    localparam int unsigned ACC_W  = 48;
    localparam int unsigned Y_W    = 40;
    localparam int unsigned SMP_W  = 16;
    localparam int unsigned WORD_W = 9;
    localparam int unsigned IDX_W  = 9;
    localparam int unsigned OP_W   = 2;

    typedef enum logic [OP_W-1:0] {
        OP_GSIZE  = 2'd0,
        OP_COEF   = 2'd1,
        OP_SAMPLE = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HWR,
        S_GRP,
        S_CRD,
        S_HRD,
        S_SER,
        S_OUT
    } t_state;
endpackage
`default_nettype wire

// ----- rtl/pgf_ram.sv -----
`default_nettype none
module pgf_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ----- rtl/pot_grouped_fir_filter_unit.sv -----
// Channel  Dir  Payload
// s_axis   in   op, index, load_word, sample
// m_axis   out  y
// A load is written as it is accepted. A sample takes a history write, then
// for each term held in the store a term select, store read, history read
// and a serial add/subtract of 3 bits a cycle, a group-select step for each
// term past the store and for each group shift, then the output state.
// After reset the history is cleared; no request is taken then. A result
// waits in the output register until taken.
`default_nettype none
module pot_grouped_fir_filter_unit #(
    parameter int unsigned HISTORY_DEPTH = 256,
    parameter int unsigned COEF_DEPTH    = 512,
    parameter int unsigned GROUP_COUNT   = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,  // op[1:0] index[10:2] load_word[19:11] sample[35:20]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata   // y[39:0]
);
    import pgf_pkg::*;

    localparam int unsigned HA = $clog2(HISTORY_DEPTH);
    localparam int unsigned CA = $clog2(COEF_DEPTH);
    localparam int unsigned GA = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;
    localparam int unsigned PW = CA + WORD_W + 1;
    localparam int unsigned DIG = 3;
    localparam int unsigned NDIG = ACC_W / DIG;

    t_state r_state, n_state;
    logic [WORD_W-1:0] r_gsize [GROUP_COUNT];
    logic [HA-1:0] r_hptr;
    logic [HA:0]   r_clr;
    logic [GA:0]   r_g;
    logic [WORD_W-1:0] r_t;
    logic [PW-1:0] r_pos;
    logic [ACC_W-1:0] r_acc, r_opd;
    logic r_sub, r_cy, r_zero;
    logic [4:0] r_dc;
    logic [Y_W-1:0] r_y;
    logic r_yv;

    t_op w_op;
    logic [IDX_W-1:0] w_idx;
    logic [WORD_W-1:0] w_word;
    logic [SMP_W-1:0] w_smp;
    assign w_op   = t_op'(s_axis_tdata[1:0]);
    assign w_idx  = s_axis_tdata[10:2];
    assign w_word = s_axis_tdata[19:11];
    assign w_smp  = s_axis_tdata[35:20];

    logic w_acc_in;
    assign s_axis_tready = (r_state == S_IDLE) && r_clr[HA] && !r_yv;
    assign w_acc_in = s_axis_tvalid && s_axis_tready;

    logic [WORD_W-1:0] w_coef;
    logic [SMP_W-1:0]  w_hist;
    logic              w_hwe;
    logic [HA-1:0]     w_hwa, w_hra;
    logic [SMP_W-1:0]  w_hwd;

    assign w_hwe = !r_clr[HA] || (r_state == S_HWR);
    assign w_hwa = r_clr[HA] ? r_hptr : r_clr[HA-1:0];
    assign w_hwd = r_clr[HA] ? r_opd[SMP_W-1:0] : '0;
    assign w_hra = r_hptr - HA'(w_coef[7:0]);

    pgf_ram #(.WIDTH(WORD_W), .DEPTH(COEF_DEPTH)) u_coef (
        .i_clk(i_clk),
        .i_we(w_acc_in && w_op == OP_COEF && 32'(w_idx) < COEF_DEPTH),
        .i_waddr(CA'(w_idx)),
        .i_wdata(w_word),
        .i_raddr(r_pos[CA-1:0]),
        .o_rdata(w_coef)
    );

    pgf_ram #(.WIDTH(SMP_W), .DEPTH(HISTORY_DEPTH)) u_hist (
        .i_clk(i_clk),
        .i_we(w_hwe),
        .i_waddr(w_hwa),
        .i_wdata(w_hwd),
        .i_raddr(w_hra),
        .o_rdata(w_hist)
    );

    logic w_gend, w_last_g, w_in_store, w_far, w_dlast;
    assign w_gend    = r_t >= r_gsize[r_g[GA-1:0]];
    assign w_last_g  = r_g == (GA+1)'(GROUP_COUNT - 1);
    assign w_in_store = r_pos < PW'(COEF_DEPTH);
    assign w_far     = 32'(w_coef[7:0]) >= HISTORY_DEPTH;
    assign w_dlast   = r_dc == 5'(NDIG - 1);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (w_acc_in && w_op == OP_SAMPLE) n_state = S_HWR;
            S_HWR:  n_state = S_GRP;
            S_GRP: begin
                if (w_gend) n_state = w_last_g ? S_OUT : S_GRP;
                else if (w_in_store) n_state = S_CRD;
                else n_state = S_GRP;
            end
            S_CRD:  n_state = S_HRD;
            S_HRD:  n_state = S_SER;
            S_SER:  if (w_dlast) n_state = S_GRP;
            S_OUT:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    logic [DIG:0] w_dsum;
    logic [DIG-1:0] w_b;
    always_comb begin
        w_b = r_sub ? ~r_opd[DIG-1:0] : r_opd[DIG-1:0];
        w_dsum = {1'b0, r_acc[DIG-1:0]} + {1'b0, w_b} + {{DIG{1'b0}}, r_cy};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_hptr  <= '0;
            r_clr   <= '0;
            r_yv    <= 1'b0;
            for (int i = 0; i < GROUP_COUNT; i++) r_gsize[i] <= '0;
        end else begin
            r_state <= n_state;
            if (!r_clr[HA]) r_clr <= r_clr + 1'b1;
            if (r_state == S_OUT) begin
                r_yv <= 1'b1;
            end else if (m_axis_tvalid && m_axis_tready) begin
                r_yv <= 1'b0;
            end
            if (w_acc_in && w_op == OP_GSIZE && 32'(w_idx) < GROUP_COUNT)
                r_gsize[w_idx[GA-1:0]] <= w_word;
            if (w_acc_in && w_op == OP_SAMPLE) r_hptr <= r_hptr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_opd <= {{(ACC_W-SMP_W){1'b0}}, w_smp};
                r_acc <= '0;
                r_g   <= '0;
                r_t   <= '0;
                r_pos <= '0;
            end
            S_GRP: begin
                if (w_gend) begin
                    r_acc <= {r_acc[ACC_W-1], r_acc[ACC_W-1:1]};
                    r_g   <= r_g + 1'b1;
                    r_t   <= '0;
                end else if (!w_in_store) begin
                    r_t   <= r_t + 1'b1;
                    r_pos <= r_pos + 1'b1;
                end
            end
            S_CRD: begin
                r_sub  <= w_coef[8];
                r_zero <= w_far;
            end
            S_HRD: begin
                r_opd <= r_zero ? '0 :
                    {{(ACC_W-SMP_W*2){w_hist[SMP_W-1]}}, w_hist, {SMP_W{1'b0}}};
                r_cy  <= r_sub;
                r_dc  <= '0;
            end
            S_SER: begin
                r_acc <= {w_dsum[DIG-1:0], r_acc[ACC_W-1:DIG]};
                r_opd <= {{DIG{1'b0}}, r_opd[ACC_W-1:DIG]};
                r_cy  <= w_dsum[DIG];
                r_dc  <= r_dc + 1'b1;
                if (w_dlast) begin
                    r_t   <= r_t + 1'b1;
                    r_pos <= r_pos + 1'b1;
                end
            end
            S_OUT: r_y <= r_acc[Y_W-1:0];
            default: ;
        endcase
    end

    assign m_axis_tvalid = r_yv;
    assign m_axis_tdata  = r_y;

    a_busy_no_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !s_axis_tready) else $error("ready while busy");
    a_out_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |=> m_axis_tvalid) else $error("result lost");
    a_ser_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SER) |-> (r_dc < 5'(NDIG))) else $error("digit count");
endmodule
`default_nettype wire
